// ===== design/dgm_pkg.sv =====
// shared constants and types for the descriptor greedy matcher
// no dependencies
package dgm_pkg;

    localparam int MAX_POINTS_DEF = 32;
    localparam int DESC_LEN_DEF   = 512;

    localparam int ELEM_W   = 16;
    localparam int PIDX_W   = 5;
    localparam int EIDX_W   = 9;
    localparam int NUM_W    = 6;
    localparam int DIST_W   = 41;
    localparam int ACC_W    = 42;
    localparam int CIDX_W   = 12;
    localparam int N_W      = 7;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 56;

    localparam logic [0:0] CFG_NUM_POINTS = 1'b0;
    localparam logic [0:0] CFG_THRESHOLD  = 1'b1;

    localparam logic [0:0] REQ_LOAD = 1'b0;
    localparam logic [0:0] REQ_RUN  = 1'b1;

    localparam logic [NUM_W-1:0]  RESET_NUM_POINTS = 6'd32;
    localparam logic [DIST_W-1:0] RESET_THRESHOLD  = 41'd2198956147200;

    typedef struct packed {
        logic              en;
        logic [CIDX_W-1:0] idx;
        logic [ACC_W-1:0]  dsq;
    } t_cand_wr;

endpackage

// ===== design/dgm_dist.sv =====
// descriptor stores and pairwise squared-distance engine
// depends on dgm_pkg
module dgm_dist #(
    parameter int MAX_POINTS = dgm_pkg::MAX_POINTS_DEF,
    parameter int DESC_LEN   = dgm_pkg::DESC_LEN_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_ld_en,
    input  logic                                i_ld_set,
    input  logic [dgm_pkg::PIDX_W-1:0]          i_ld_point,
    input  logic [dgm_pkg::EIDX_W-1:0]          i_ld_elem,
    input  logic signed [dgm_pkg::ELEM_W-1:0]   i_ld_value,
    input  logic                                i_start,
    input  logic [dgm_pkg::N_W-1:0]             i_n,
    output dgm_pkg::t_cand_wr                   o_cand,
    output logic                                o_done
);
    localparam int PW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int KW    = (DESC_LEN > 1) ? $clog2(DESC_LEN) : 1;
    localparam int DEPTH = MAX_POINTS * DESC_LEN;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef struct packed {
        logic          first;
        logic          last;
        logic [PW-1:0] i;
        logic [PW-1:0] j;
    } t_tag;

    logic signed [dgm_pkg::ELEM_W-1:0] r_mem_a [DEPTH];
    logic signed [dgm_pkg::ELEM_W-1:0] r_mem_b [DEPTH];
    logic signed [dgm_pkg::ELEM_W-1:0] r_qa, r_qb;

    logic          r_busy, r_run;
    logic [PW-1:0] r_i, r_j;
    logic [KW-1:0] r_k;
    logic [dgm_pkg::N_W-1:0] r_nm1;
    logic          r_v1, r_v2, r_v3;
    t_tag          r_t1, r_t2, r_t3;
    logic signed [dgm_pkg::ELEM_W:0] r_diff;
    logic [31:0]   r_sq;
    logic [dgm_pkg::ACC_W-1:0] r_acc;
    logic          r_cw_en;
    logic [dgm_pkg::CIDX_W-1:0] r_cw_idx;

    logic [AW-1:0] ld_addr, rd_addr_a, rd_addr_b, addr_a, addr_b;
    logic          k_last, j_last, i_last;
    logic signed [2*dgm_pkg::ELEM_W+1:0] prod;
    logic [dgm_pkg::ACC_W-1:0] n_acc;

    assign ld_addr   = AW'(i_ld_point * DESC_LEN) + AW'(i_ld_elem);
    // first set is walked by row index, second set by column index
    assign rd_addr_a = AW'(r_i * DESC_LEN) + AW'(r_k);
    assign rd_addr_b = AW'(r_j * DESC_LEN) + AW'(r_k);
    assign addr_a    = r_run ? rd_addr_a : ld_addr;
    assign addr_b    = r_run ? rd_addr_b : ld_addr;

    assign k_last = (r_k == KW'(DESC_LEN - 1));
    assign j_last = (dgm_pkg::N_W'(r_j) == r_nm1);
    assign i_last = (dgm_pkg::N_W'(r_i) == r_nm1);

    assign prod  = r_diff * r_diff;
    assign n_acc = (r_t3.first ? '0 : r_acc) + dgm_pkg::ACC_W'(r_sq);

    always_ff @(posedge i_clk) begin
        if (i_ld_en && !r_run && !i_ld_set) begin
            r_mem_a[addr_a] <= i_ld_value;
        end
        if (i_ld_en && !r_run && i_ld_set) begin
            r_mem_b[addr_b] <= i_ld_value;
        end
        r_qa <= r_mem_a[addr_a];
        r_qb <= r_mem_b[addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_run   <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_cw_en <= 1'b0;
        end else begin
            r_v1    <= r_run;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_cw_en <= r_v3 && r_t3.last;
            if (i_start) begin
                r_busy <= 1'b1;
                r_run  <= (i_n != '0);
            end else if (r_run && k_last && j_last && i_last) begin
                r_run <= 1'b0;
            end else if (o_done) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_i   <= '0;
            r_j   <= '0;
            r_k   <= '0;
            r_nm1 <= i_n - dgm_pkg::N_W'(1);
        end else if (r_run) begin
            if (k_last) begin
                r_k <= '0;
                if (j_last) begin
                    r_j <= '0;
                    r_i <= r_i + PW'(1);
                end else begin
                    r_j <= r_j + PW'(1);
                end
            end else begin
                r_k <= r_k + KW'(1);
            end
        end
        r_t1.first <= (r_k == '0);
        r_t1.last  <= k_last;
        r_t1.i     <= r_i;
        r_t1.j     <= r_j;
        r_t2       <= r_t1;
        r_t3       <= r_t2;
        r_diff     <= (dgm_pkg::ELEM_W+1)'(r_qa) - (dgm_pkg::ELEM_W+1)'(r_qb);
        r_sq       <= prod[31:0];
        if (r_v3) begin
            r_acc    <= n_acc;
            r_cw_idx <= dgm_pkg::CIDX_W'({r_t3.i, r_t3.j});
        end
    end

    assign o_cand.en  = r_cw_en;
    assign o_cand.idx = r_cw_idx;
    assign o_cand.dsq = r_acc;
    assign o_done = r_busy && !r_run && !r_v1 && !r_v2 && !r_v3 && !r_cw_en && !i_start;

endmodule

// ===== design/dgm_grant.sv =====
// candidate store, greedy minimum scan with used marks, and result register
// depends on dgm_pkg
module dgm_grant #(
    parameter int MAX_POINTS = dgm_pkg::MAX_POINTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dgm_pkg::t_cand_wr             i_cand,
    input  logic [dgm_pkg::DIST_W-1:0]    i_thr,
    input  logic                          i_start,
    input  logic [dgm_pkg::N_W-1:0]       i_n,
    input  logic                          i_ready,
    output logic                          o_valid,
    output logic                          o_found,
    output logic [dgm_pkg::PIDX_W-1:0]    o_first,
    output logic [dgm_pkg::PIDX_W-1:0]    o_second,
    output logic [dgm_pkg::DIST_W-1:0]    o_dist,
    output logic                          o_last,
    output logic                          o_done
);
    localparam int PW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CDEPTH = 1 << (2 * PW);
    localparam int EW    = dgm_pkg::ACC_W + 1;

    localparam logic [1:0] G_IDLE   = 2'd0;
    localparam logic [1:0] G_SCAN   = 2'd1;
    localparam logic [1:0] G_DECIDE = 2'd2;

    logic [EW-1:0] r_mem [CDEPTH];
    logic [EW-1:0] r_rd;
    logic [1:0]    r_state;
    logic          r_scan_on, r_v1;
    logic [PW-1:0] r_si, r_sj, r_a1, r_b1;
    logic [dgm_pkg::N_W-1:0] r_nm1;
    logic          r_best_v, r_pend_v;
    logic [PW-1:0] r_best_a, r_best_b, r_pend_a, r_pend_b;
    logic [dgm_pkg::ACC_W-1:0] r_best_d, r_pend_d;
    logic [MAX_POINTS-1:0] r_used_a, r_used_b;
    logic          r_valid, r_found, r_last, r_done;
    logic [dgm_pkg::PIDX_W-1:0] r_first, r_second;
    logic [dgm_pkg::DIST_W-1:0] r_dist;

    logic          out_free, better, sj_last, si_last, cand_ok;

    assign out_free = !r_valid || i_ready;
    assign sj_last  = (dgm_pkg::N_W'(r_sj) == r_nm1);
    assign si_last  = (dgm_pkg::N_W'(r_si) == r_nm1);
    assign better   = r_v1 && r_rd[EW-1] && !r_used_a[r_a1] && !r_used_b[r_b1]
                      && (!r_best_v || (r_rd[dgm_pkg::ACC_W-1:0] < r_best_d));
    assign cand_ok  = (i_cand.dsq <= dgm_pkg::ACC_W'(i_thr));

    always_ff @(posedge i_clk) begin
        if (i_cand.en) begin
            r_mem[i_cand.idx[2*PW-1:0]] <= {cand_ok, i_cand.dsq};
        end
        r_rd <= r_mem[{r_si, r_sj}];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= G_IDLE;
            r_scan_on <= 1'b0;
            r_v1      <= 1'b0;
            r_best_v  <= 1'b0;
            r_pend_v  <= 1'b0;
            r_used_a  <= '0;
            r_used_b  <= '0;
            r_valid   <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_v1   <= r_scan_on;
            r_a1   <= r_si;
            r_b1   <= r_sj;
            if (i_ready) begin
                r_valid <= 1'b0;
            end
            if (better) begin
                r_best_v <= 1'b1;
                r_best_d <= r_rd[dgm_pkg::ACC_W-1:0];
                r_best_a <= r_a1;
                r_best_b <= r_b1;
            end
            unique case (r_state)
                G_IDLE: begin
                    if (i_start) begin
                        r_state   <= G_SCAN;
                        r_nm1     <= i_n - dgm_pkg::N_W'(1);
                        r_si      <= '0;
                        r_sj      <= '0;
                        r_scan_on <= (i_n != '0);
                        r_best_v  <= 1'b0;
                        r_pend_v  <= 1'b0;
                        r_used_a  <= '0;
                        r_used_b  <= '0;
                    end
                end
                G_SCAN: begin
                    if (r_scan_on) begin
                        if (sj_last) begin
                            r_sj <= '0;
                            r_si <= r_si + PW'(1);
                            if (si_last) begin
                                r_scan_on <= 1'b0;
                            end
                        end else begin
                            r_sj <= r_sj + PW'(1);
                        end
                    end else if (!r_v1) begin
                        r_state <= G_DECIDE;
                    end
                end
                G_DECIDE: begin
                    if (r_best_v) begin
                        if (!r_pend_v || out_free) begin
                            if (r_pend_v) begin
                                r_valid  <= 1'b1;
                                r_found  <= 1'b1;
                                r_first  <= dgm_pkg::PIDX_W'(r_pend_a);
                                r_second <= dgm_pkg::PIDX_W'(r_pend_b);
                                r_dist   <= r_pend_d[dgm_pkg::DIST_W-1:0];
                                r_last   <= 1'b0;
                            end
                            r_pend_v <= 1'b1;
                            r_pend_a <= r_best_a;
                            r_pend_b <= r_best_b;
                            r_pend_d <= r_best_d;
                            r_used_a[r_best_a] <= 1'b1;
                            r_used_b[r_best_b] <= 1'b1;
                            r_best_v  <= 1'b0;
                            r_si      <= '0;
                            r_sj      <= '0;
                            r_scan_on <= 1'b1;
                            r_state   <= G_SCAN;
                        end
                    end else if (out_free) begin
                        r_valid  <= 1'b1;
                        r_found  <= r_pend_v;
                        r_first  <= r_pend_v ? dgm_pkg::PIDX_W'(r_pend_a) : '0;
                        r_second <= r_pend_v ? dgm_pkg::PIDX_W'(r_pend_b) : '0;
                        r_dist   <= r_pend_v ? r_pend_d[dgm_pkg::DIST_W-1:0] : '0;
                        r_last   <= 1'b1;
                        r_pend_v <= 1'b0;
                        r_done   <= 1'b1;
                        r_state  <= G_IDLE;
                    end
                end
                default: begin
                    r_state <= G_IDLE;
                end
            endcase
        end
    end

    assign o_valid  = r_valid;
    assign o_found  = r_found;
    assign o_first  = r_first;
    assign o_second = r_second;
    assign o_dist   = r_dist;
    assign o_last   = r_last;
    assign o_done   = r_done;

endmodule

// ===== design/descriptor_greedy_matcher.sv =====
// top level of the greedy one-to-one descriptor matcher
// depends on dgm_pkg, dgm_dist and dgm_grant
//
// Load beats (tuser[0] = 0) write one Q1.15 descriptor element each and are
// taken one per cycle while no run is in progress. A run beat (tuser[0] = 1)
// computes the squared distance of every first/second descriptor pair (one
// element pair per cycle through the two element memories), then grants
// pairs greedily: each grant is one scan of the candidate memory for the
// smallest unused pair within the threshold. Results come out in ascending
// distance, ties in row-major order, with tlast on the final one; a run with
// no pair gives one beat with tuser (found) low. The input stays stalled
// until the last result of a run sits in the output register.
module descriptor_greedy_matcher #(
    parameter int MAX_POINTS = dgm_pkg::MAX_POINTS_DEF,
    parameter int DESC_LEN   = dgm_pkg::DESC_LEN_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // config write port
    input  logic                              i_cfg_we,
    input  logic [0:0]                        i_cfg_addr,
    input  logic [dgm_pkg::DIST_W-1:0]        i_cfg_wdata,
    // request stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // point_index[4:0], element_index[13:5], element_value[29:14], zero pad
    input  logic [dgm_pkg::S_DATA_W-1:0]      s_axis_tdata,
    // req_type[0], which_set[1]
    input  logic [1:0]                        s_axis_tuser,
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // first_index[4:0], second_index[9:5], distance_sq[50:10], zero pad
    output logic [dgm_pkg::M_DATA_W-1:0]      m_axis_tdata,
    // found[0]
    output logic [0:0]                        m_axis_tuser,
    output logic                              m_axis_tlast
);
    localparam int LIMIT = (MAX_POINTS < 32) ? MAX_POINTS : 32;

    logic [dgm_pkg::NUM_W-1:0]  r_num;
    logic [dgm_pkg::DIST_W-1:0] r_thr;
    logic                       r_busy;

    logic                       acc_in, ld_en, run_go, dist_done, grant_done;
    logic [dgm_pkg::N_W-1:0]    n_eff;
    logic [dgm_pkg::PIDX_W-1:0] ld_point;
    logic [dgm_pkg::EIDX_W-1:0] ld_elem;
    logic                       ld_in_range;
    dgm_pkg::t_cand_wr          cand;
    logic                       g_found, g_last;
    logic [dgm_pkg::PIDX_W-1:0] g_first, g_second;
    logic [dgm_pkg::DIST_W-1:0] g_dist;

    assign s_axis_tready = !r_busy;
    assign acc_in = s_axis_tvalid && s_axis_tready;

    assign ld_point = s_axis_tdata[4:0];
    assign ld_elem  = s_axis_tdata[13:5];
    // out-of-range loads are dropped
    assign ld_in_range = (32'(ld_point) < MAX_POINTS) && (32'(ld_elem) < DESC_LEN);
    assign ld_en  = acc_in && (s_axis_tuser[0] == dgm_pkg::REQ_LOAD) && ld_in_range;
    assign run_go = acc_in && (s_axis_tuser[0] == dgm_pkg::REQ_RUN);

    // point count saturates at the store size and at 32
    assign n_eff = (32'(r_num) > LIMIT) ? dgm_pkg::N_W'(LIMIT) : dgm_pkg::N_W'(r_num);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num  <= dgm_pkg::RESET_NUM_POINTS;
            r_thr  <= dgm_pkg::RESET_THRESHOLD;
            r_busy <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    dgm_pkg::CFG_NUM_POINTS: r_num <= i_cfg_wdata[dgm_pkg::NUM_W-1:0];
                    dgm_pkg::CFG_THRESHOLD:  r_thr <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (run_go) begin
                r_busy <= 1'b1;
            end else if (grant_done) begin
                r_busy <= 1'b0;
            end
        end
    end

    dgm_dist #(
        .MAX_POINTS (MAX_POINTS),
        .DESC_LEN   (DESC_LEN)
    ) u_dist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ld_en    (ld_en),
        .i_ld_set   (s_axis_tuser[1]),
        .i_ld_point (ld_point),
        .i_ld_elem  (ld_elem),
        .i_ld_value (s_axis_tdata[29:14]),
        .i_start    (run_go),
        .i_n        (n_eff),
        .o_cand     (cand),
        .o_done     (dist_done)
    );

    dgm_grant #(
        .MAX_POINTS (MAX_POINTS)
    ) u_grant (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cand   (cand),
        .i_thr    (r_thr),
        .i_start  (dist_done),
        .i_n      (n_eff),
        .i_ready  (m_axis_tready),
        .o_valid  (m_axis_tvalid),
        .o_found  (g_found),
        .o_first  (g_first),
        .o_second (g_second),
        .o_dist   (g_dist),
        .o_last   (g_last),
        .o_done   (grant_done)
    );

    assign m_axis_tdata = {5'd0, g_dist, g_second, g_first};
    assign m_axis_tuser = g_found;
    assign m_axis_tlast = g_last;

endmodule
